/* sv/imh_pkg.sv */
// Shared constants, codes and field types for the indexed min-heap.
package imh_pkg;

  localparam int KEY_W       = 10;
  localparam int KEY_COUNT   = 1 << KEY_W;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int PRIO_PORT_W = 32;
  localparam int PAY_PORT_W  = 16;
  localparam int OCC_W       = 11;

  localparam int CAPACITY_DEF      = 1024;
  localparam int PRIORITY_BITS_DEF = 32;
  localparam int PAYLOAD_BITS_DEF  = 16;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_INSERT   = 2'd0;
  localparam mode_t MODE_POP      = 2'd1;
  localparam mode_t MODE_DECREASE = 2'd2;

  localparam status_t ST_OK          = 3'd0;
  localparam status_t ST_FULL        = 3'd1;
  localparam status_t ST_EMPTY       = 3'd2;
  localparam status_t ST_ABSENT      = 3'd3;
  localparam status_t ST_NOT_SMALLER = 3'd4;
  localparam status_t ST_PRESENT     = 3'd5;

endpackage

/* sv/imh_req_if.sv */
// Request channel: operation, key, priority and payload with valid/ready.
interface imh_req_if;
  logic                             valid;
  logic                             ready;
  imh_pkg::mode_t                   mode;
  logic [imh_pkg::KEY_W-1:0]        key;
  logic [imh_pkg::PRIO_PORT_W-1:0]  priority_req;
  logic [imh_pkg::PAY_PORT_W-1:0]   payload;

  modport source (output valid, mode, key, priority_req, payload, input ready);
  modport sink (input valid, mode, key, priority_req, payload, output ready);
endinterface

/* sv/imh_rsp_if.sv */
// Response channel: status, popped entry and occupancy with valid/ready.
interface imh_rsp_if;
  logic                             valid;
  logic                             ready;
  imh_pkg::status_t                 status;
  logic [imh_pkg::KEY_W-1:0]        out_key;
  logic [imh_pkg::PRIO_PORT_W-1:0]  out_priority;
  logic [imh_pkg::PAY_PORT_W-1:0]   out_payload;
  logic [imh_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, status, out_key, out_priority, out_payload, occupancy,
                  input ready);
  modport sink (input valid, status, out_key, out_priority, out_payload, occupancy,
                output ready);
endinterface

/* sv/imh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/imh_cmp.sv */
// Shared priority comparator: flags a strictly larger first operand.
module imh_cmp #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic             gt
);

  assign gt = (a > b);

endmodule

/* sv/indexed_min_heap_decrease_key.sv */
// Indexed binary min-heap with insert, pop-minimum and decrease-priority.
//
// Requests arrive on req (valid/ready); each gives exactly one word on rsp
// carrying a status, the popped entry (zero unless a pop succeeds) and the
// entry count after the request. One request is worked at a time; req.ready
// is high only while the sequencer is idle, so the next request is taken in
// the cycle after the previous word is loaded at the earliest.
// With 1024 slots an entry moves at most 10 heap levels in a sift.
// Each sift step is bounded by the heap memory's single read port: it reads
// the parent, or both children one after the other, and then compares them
// in the one shared comparator before writing the moved entry back.
// After reset the key-to-slot table is swept to zero, one entry a cycle,
// for all 1024 keys; req.ready stays low throughout.
// A finished response sits in an output register; a new request is taken
// while it waits, but the next response is held back until rsp is taken.
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY      = imh_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = imh_pkg::PRIORITY_BITS_DEF,
  parameter int PAYLOAD_BITS  = imh_pkg::PAYLOAD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  imh_req_if.sink  req,
  imh_rsp_if.source rsp
);

  localparam int KEY_W     = imh_pkg::KEY_W;
  localparam int KEY_COUNT = imh_pkg::KEY_COUNT;
  localparam int PW        = imh_pkg::PRIO_PORT_W;
  localparam int YW        = imh_pkg::PAY_PORT_W;
  localparam int OCC_W     = imh_pkg::OCC_W;
  localparam int SLOT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W   = KEY_W + PRIORITY_BITS + PAYLOAD_BITS;
  localparam int PRIO_LSB  = PAYLOAD_BITS;
  localparam int KEY_LSB   = PAYLOAD_BITS + PRIORITY_BITS;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_INS      = 4'd2;
  localparam logic [3:0] S_DEC      = 4'd3;
  localparam logic [3:0] S_DEC_CHK  = 4'd4;
  localparam logic [3:0] S_POP1     = 4'd5;
  localparam logic [3:0] S_POP2     = 4'd6;
  localparam logic [3:0] S_RISE     = 4'd7;
  localparam logic [3:0] S_RISE_W   = 4'd8;
  localparam logic [3:0] S_SINK     = 4'd9;
  localparam logic [3:0] S_SINK_L   = 4'd10;
  localparam logic [3:0] S_SINK_R   = 4'd11;
  localparam logic [3:0] S_SINK_CMP = 4'd12;
  localparam logic [3:0] S_PLACE    = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  logic [3:0]              state;
  logic [KEY_W-1:0]        clr;
  logic [SLOT_W-1:0]       cnt;
  logic [SLOT_W-1:0]       pos;
  logic [SLOT_W:0]         cidx;
  logic [KEY_W-1:0]        mover_key;
  logic [PRIORITY_BITS-1:0] mover_prio;
  logic [PAYLOAD_BITS-1:0] mover_pay;
  logic [ENTRY_W-1:0]      cand;
  imh_pkg::status_t        st;
  logic [KEY_W-1:0]        top_key;
  logic [PRIORITY_BITS-1:0] top_prio;
  logic [PAYLOAD_BITS-1:0] top_pay;

  logic                    out_valid;
  logic                    rsp_load;
  imh_pkg::status_t        o_status;
  logic [KEY_W-1:0]        o_key;
  logic [PW-1:0]           o_prio;
  logic [YW-1:0]           o_pay;
  logic [OCC_W-1:0]        o_occ;

  logic                    heap_we;
  logic [SLOT_W-1:0]       heap_waddr;
  logic [ENTRY_W-1:0]      heap_wdata;
  logic [SLOT_W-1:0]       heap_raddr;
  logic [ENTRY_W-1:0]      heap_rdata;
  logic                    key_we;
  logic [KEY_W-1:0]        key_waddr;
  logic [SLOT_W-1:0]       key_wdata;
  logic [KEY_W-1:0]        key_raddr;
  logic [SLOT_W-1:0]       key_rdata;

  logic [PRIORITY_BITS-1:0] cmp_a;
  logic [PRIORITY_BITS-1:0] cmp_b;
  logic                    gt;
  logic [SLOT_W:0]         child;

  logic [KEY_W-1:0]         rd_key;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic [KEY_W-1:0]         cand_key;
  logic [PRIORITY_BITS-1:0] cand_prio;
  logic [ENTRY_W-1:0]       mover_e;

  assign rd_key    = heap_rdata[KEY_LSB +: KEY_W];
  assign rd_prio   = heap_rdata[PRIO_LSB +: PRIORITY_BITS];
  assign rd_pay    = heap_rdata[PAYLOAD_BITS-1:0];
  assign cand_key  = cand[KEY_LSB +: KEY_W];
  assign cand_prio = cand[PRIO_LSB +: PRIORITY_BITS];
  assign mover_e   = {mover_key, mover_prio, mover_pay};
  assign child     = {pos, 1'b0};

  imh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY + 1)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imh_ram #(.WIDTH(SLOT_W), .DEPTH(KEY_COUNT)) u_slot (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  imh_cmp #(.WIDTH(PRIORITY_BITS)) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (gt)
  );

  // Memory ports and comparator operands, steered by the sequencer state
  always_comb begin
    heap_raddr = SLOT_W'(1);
    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = mover_e;
    key_raddr  = req.key;
    key_we     = 1'b0;
    key_waddr  = mover_key;
    key_wdata  = pos;
    cmp_a      = rd_prio;
    cmp_b      = mover_prio;
    unique case (state)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr;
        key_wdata = '0;
      end
      S_DEC: begin
        heap_raddr = key_rdata;
      end
      S_POP1: begin
        // drop the popped key from the table, fetch the last entry
        heap_raddr = cnt;
        key_we     = 1'b1;
        key_waddr  = rd_key;
        key_wdata  = '0;
      end
      S_RISE: begin
        heap_raddr = pos >> 1;
      end
      S_RISE_W: begin
        if (gt) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          key_we     = 1'b1;
          key_waddr  = rd_key;
        end
      end
      S_SINK: begin
        heap_raddr = SLOT_W'(child);
      end
      S_SINK_L: begin
        heap_raddr = SLOT_W'(cidx + (SLOT_W+1)'(1));
      end
      S_SINK_R: begin
        cmp_a = cand_prio;
        cmp_b = rd_prio;
      end
      S_SINK_CMP: begin
        cmp_a = mover_prio;
        cmp_b = cand_prio;
        if (gt) begin
          heap_we    = 1'b1;
          heap_wdata = cand;
          key_we     = 1'b1;
          key_waddr  = cand_key;
        end
      end
      S_PLACE: begin
        heap_we = 1'b1;
        key_we  = 1'b1;
      end
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  // Output word: load a finished response, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      cnt       <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr <= clr + KEY_W'(1);
          if (clr == KEY_W'(KEY_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            mover_key  <= req.key;
            mover_prio <= PRIORITY_BITS'(req.priority_req);
            mover_pay  <= PAYLOAD_BITS'(req.payload);
            st         <= imh_pkg::ST_OK;
            top_key    <= '0;
            top_prio   <= '0;
            top_pay    <= '0;
            unique case (req.mode)
              imh_pkg::MODE_INSERT: begin
                if (cnt == SLOT_W'(CAPACITY)) begin
                  st    <= imh_pkg::ST_FULL;
                  state <= S_DONE;
                end else begin
                  state <= S_INS;
                end
              end
              imh_pkg::MODE_POP: begin
                if (cnt == '0) begin
                  st    <= imh_pkg::ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  state <= S_POP1;
                end
              end
              imh_pkg::MODE_DECREASE: begin
                state <= S_DEC;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (key_rdata != '0) begin
            st    <= imh_pkg::ST_PRESENT;
            state <= S_DONE;
          end else begin
            pos   <= cnt + SLOT_W'(1);
            cnt   <= cnt + SLOT_W'(1);
            state <= S_RISE;
          end
        end
        S_DEC: begin
          if (key_rdata == '0 || key_rdata > cnt) begin
            st    <= imh_pkg::ST_ABSENT;
            state <= S_DONE;
          end else begin
            pos   <= key_rdata;
            state <= S_DEC_CHK;
          end
        end
        S_DEC_CHK: begin
          if (gt) begin
            state <= S_RISE;
          end else begin
            st    <= imh_pkg::ST_NOT_SMALLER;
            state <= S_DONE;
          end
        end
        S_POP1: begin
          top_key  <= rd_key;
          top_prio <= rd_prio;
          top_pay  <= rd_pay;
          if (cnt == SLOT_W'(1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            state <= S_POP2;
          end
        end
        S_POP2: begin
          // last entry becomes the mover, sunk from the root
          mover_key  <= rd_key;
          mover_prio <= rd_prio;
          mover_pay  <= rd_pay;
          cnt        <= cnt - SLOT_W'(1);
          pos        <= SLOT_W'(1);
          state      <= S_SINK;
        end
        S_RISE: begin
          if (pos == SLOT_W'(1)) begin
            state <= S_PLACE;
          end else begin
            state <= S_RISE_W;
          end
        end
        S_RISE_W: begin
          if (gt) begin
            pos   <= pos >> 1;
            state <= S_RISE;
          end else begin
            state <= S_PLACE;
          end
        end
        S_SINK: begin
          cidx <= child;
          if (child > {1'b0, cnt}) begin
            state <= S_PLACE;
          end else begin
            state <= S_SINK_L;
          end
        end
        S_SINK_L: begin
          cand <= heap_rdata;
          if (cidx < {1'b0, cnt}) begin
            state <= S_SINK_R;
          end else begin
            state <= S_SINK_CMP;
          end
        end
        S_SINK_R: begin
          // right child only on a strictly smaller priority
          if (gt) begin
            cand <= heap_rdata;
            cidx <= cidx + (SLOT_W+1)'(1);
          end
          state <= S_SINK_CMP;
        end
        S_SINK_CMP: begin
          if (gt) begin
            pos   <= SLOT_W'(cidx);
            state <= S_SINK;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (rsp_load) begin
            o_status  <= st;
            o_key     <= top_key;
            o_prio    <= PW'(top_prio);
            o_pay     <= YW'(top_pay);
            o_occ     <= OCC_W'(cnt);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = o_status;
  assign rsp.out_key      = o_key;
  assign rsp.out_priority = o_prio;
  assign rsp.out_payload  = o_pay;
  assign rsp.occupancy    = o_occ;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= SLOT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == imh_pkg::ST_FULL |-> rsp.occupancy == OCC_W'(CAPACITY))
    else $error("full refusal with heap not full");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != imh_pkg::ST_OK
      |-> rsp.out_key == '0 && rsp.out_priority == '0 && rsp.out_payload == '0)
    else $error("refused request carries an entry");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !rsp.ready |=> state == S_DONE && out_valid)
    else $error("response overwritten while stalled");

endmodule
